// ===== rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, constants and the arctangent table of the pitch solver.
// ----------------------------------------------------------------------------
package bps_pkg;

	// Fixed-point constants, Q16.16 unless noted; the step and pass counts are plain integers
	localparam int unsigned GRAV_Q16       = 640942;     // 9.78 m/s^2
	localparam int unsigned TOL_Q16        = 66;         // about 1 mm
	localparam int unsigned U_CAP          = 786432;     // 12.0
	localparam int unsigned T_CAP          = 67108864;   // 1024.0 s
	localparam int unsigned AIM_CAP        = 1073741824; // 2^30
	localparam int unsigned TIME_MAX       = 655360;     // 10.0 s
	localparam int unsigned HALF_PI_Q16    = 102944;
	localparam int unsigned SER_LAST       = 63;         // last series term index
	localparam int unsigned CORDIC_STEPS   = 17;
	localparam int unsigned NORM_LIMIT     = 536870912;  // 2^29
	localparam int unsigned DEF_MAX_PASSES = 20;

	// Divider and square-root unit sizes
	localparam int unsigned DIV_NW     = 61;  // dividend bits
	localparam int unsigned DIV_DW     = 22;  // divisor bits
	localparam int unsigned DIV_CW     = 6;   // step count bits
	localparam int unsigned SER_NW     = 36;  // series dividend bits
	localparam int unsigned SQ_IW      = 61;  // radicand bits
	localparam int unsigned SQ_RW      = 31;  // root bits

	// Configuration registers
	localparam logic [15:0] DRAG_RST = 16'd2621;
	localparam logic [16:0] LAG_RST  = 17'd5243;
	localparam logic [1:0]  REG_DRAG = 2'd0;
	localparam logic [1:0]  REG_LAG  = 2'd1;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE, ST_U, ST_SMUL, ST_SDIV, ST_SWAIT, ST_SACC,
		ST_SQ, ST_RT, ST_RWAIT, ST_RTAKE, ST_FR, ST_TDIV, ST_TWAIT, ST_TTAKE,
		ST_T2, ST_AF, ST_G1, ST_G2, ST_Z, ST_MISS, ST_UPD,
		ST_CINIT, ST_CNORM, ST_CROT, ST_FIN
	} bps_state_t;

	// Datapath operations
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_U, OP_SMUL, OP_SDIV, OP_SACC,
		OP_SQ, OP_RT, OP_RTAKE, OP_FR, OP_TDIV, OP_TTAKE,
		OP_T2, OP_AF, OP_G1, OP_G2, OP_Z, OP_MISS, OP_UPD,
		OP_CINIT, OP_CNORM, OP_CROT, OP_FIN
	} bps_op_t;

	typedef struct packed {
		bps_op_t op;
		logic    div_start;
		logic    sqrt_start;
	} bps_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic term_zero;
		logic n_last;
		logic miss_small;
		logic y_zero;
		logic norm_done;
		logic rot_last;
	} bps_stat_t;

	// atan(2^-i) in Q16.16, rounded
	function automatic logic [16:0] atan_tab(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0:    v = 17'd51472;
			5'd1:    v = 17'd30386;
			5'd2:    v = 17'd16055;
			5'd3:    v = 17'd8150;
			5'd4:    v = 17'd4091;
			5'd5:    v = 17'd2047;
			5'd6:    v = 17'd1024;
			5'd7:    v = 17'd512;
			5'd8:    v = 17'd256;
			5'd9:    v = 17'd128;
			5'd10:   v = 17'd64;
			5'd11:   v = 17'd32;
			5'd12:   v = 17'd16;
			5'd13:   v = 17'd8;
			5'd14:   v = 17'd4;
			5'd15:   v = 17'd2;
			5'd16:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/bps_div.sv =====
// ----------------------------------------------------------------------------
// bps_div
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module bps_div import bps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	input  logic [DIV_CW-1:0] steps,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic              run_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   rem2;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// Trial subtract of the divisor
	always_comb begin
		rem2 = {rem_q, num_q[DIV_NW-1]};
		diff = rem2 - {1'b0, den_q};
		ge   = (rem2 >= {1'b0, den_q});
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend, remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DIV_NW-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_DW-1:0] : rem2[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/bps_sqrt.sv =====
// ----------------------------------------------------------------------------
// bps_sqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bps_sqrt import bps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_IW-1:0] rad,
	output logic             done,
	output logic [SQ_RW-1:0] root
);

	localparam int unsigned SW = 2 * SQ_RW;
	localparam int unsigned RW = SQ_RW + 3;
	localparam int unsigned CW = $clog2(SQ_RW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] src_q;
	logic [RW-1:0] rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [RW-1:0] rem2;
	logic [RW-1:0] trial;
	logic          ge;

	// Bring down two bits, try 4*root+1
	always_comb begin
		rem2  = {rem_q[RW-3:0], src_q[SW-1:SW-2]};
		trial = RW'({root_q, 2'b01});
		ge    = (rem2 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(SQ_RW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= SW'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			src_q  <= {src_q[SW-3:0], 2'b00};
			rem_q  <= ge ? (rem2 - trial) : rem2;
			root_q <= {root_q[SQ_RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/bps_dp.sv =====
// ----------------------------------------------------------------------------
// bps_dp
// Solver datapath: drag series, aim correction passes and CORDIC atan2.
// ----------------------------------------------------------------------------
module bps_dp import bps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  bps_cmd_t           cmd,
	output bps_stat_t          stat,
	input  logic [15:0]        drag,
	input  logic [16:0]        lag,
	input  logic [21:0]        distance,
	input  logic signed [21:0] height,
	input  logic [13:0]        launch_speed,
	output logic signed [17:0] pitch_angle,
	output logic [19:0]        flight_time
);

	// Operand registers
	logic [21:0]        d_q;
	logic signed [21:0] h_q;
	logic [21:0]        v16_q;
	logic [43:0]        dd_q;
	logic [19:0]        u_q;
	logic [31:0]        term_q;
	logic [30:0]        f_q;
	logic [5:0]         n_q;
	logic [SER_NW-1:0]  sp_q;
	logic signed [31:0] a_q;
	logic [SQ_IW-1:0]   aa2_q;
	logic [SQ_RW-1:0]   r_q;
	logic [DIV_NW-1:0]  fr_q;
	logic [26:0]        t_q;
	logic [36:0]        t2_q;
	logic signed [47:0] af_q;
	logic [37:0]        gl_q;
	logic [38:0]        gh_q;
	logic [39:0]        gs_q;
	logic signed [49:0] miss_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [18:0] ang_q;
	logic [4:0]         i_q;
	logic signed [17:0] pitch_q;
	logic [19:0]        flight_q;

	// Combinational terms
	logic [37:0]        kd;
	logic [19:0]        u_next;
	logic [51:0]        sprod;
	logic [31:0]        a_abs;
	logic [61:0]        aa2;
	logic [61:0]        fr;
	logic [53:0]        tt;
	logic signed [63:0] af;
	logic [56:0]        gsum;
	logic signed [49:0] miss_next;
	logic signed [50:0] a_sum;
	logic signed [31:0] a_next;
	logic [33:0]        x_abs;
	logic [33:0]        y_abs;
	logic signed [33:0] x_sh;
	logic signed [33:0] y_sh;
	logic signed [18:0] tab;
	logic [27:0]        ft_sum;

	// Shared units
	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_CW-1:0] div_steps;
	logic              div_done;
	logic [DIV_NW-1:0] div_q;
	logic              sq_done;
	logic [SQ_RW-1:0]  sq_root;

	// Route the divider to the series or to the flight time
	always_comb begin
		div_start = cmd.div_start;
		if (cmd.op == OP_TDIV) begin
			div_num   = fr_q;
			div_den   = v16_q;
			div_steps = DIV_CW'(DIV_NW);
		end else begin
			div_num   = {sp_q, (DIV_NW - SER_NW)'(0)};
			div_den   = DIV_DW'(n_q) + DIV_DW'(1);
			div_steps = DIV_CW'(SER_NW);
		end
	end

	bps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.done   (div_done),
		.quo    (div_q)
	);

	bps_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (SQ_IW'(dd_q) + aa2_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Products, sums and compares of the current step
	always_comb begin
		kd        = drag * d_q;
		u_next    = (kd[37:16] > 22'(U_CAP)) ? 20'(U_CAP) : kd[35:16];
		sprod     = term_q * u_q;
		a_abs     = a_q[31] ? -a_q : a_q;
		aa2       = a_abs[30:0] * a_abs[30:0];
		fr        = f_q * r_q;
		tt        = t_q * t_q;
		af        = a_q * $signed({1'b0, f_q});
		gsum      = {gh_q, 18'd0} + 57'(gl_q);
		miss_next = 50'(h_q) - 50'(af_q) + $signed({10'd0, gs_q});
		a_sum     = 51'(a_q) + 51'(miss_q);
		if (a_sum > $signed(51'(AIM_CAP)))
			a_next = 32'(AIM_CAP);
		else if (a_sum < -$signed(51'(AIM_CAP)))
			a_next = -32'(AIM_CAP);
		else
			a_next = a_sum[31:0];
		x_abs     = x_q[33] ? -x_q : x_q;
		y_abs     = y_q[33] ? -y_q : y_q;
		x_sh      = x_q >>> i_q;
		y_sh      = y_q >>> i_q;
		tab       = $signed({2'b00, atan_tab(i_q)});
		ft_sum    = 28'(t_q) + 28'(lag);
	end

	// Register updates per operation
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d_q   <= distance;
				h_q   <= height;
				v16_q <= {launch_speed, 8'd0};
				dd_q  <= distance * distance;
				a_q   <= 32'(height);
			end
			OP_U: begin
				u_q    <= u_next;
				term_q <= 32'd65536;
				f_q    <= 31'd65536;
				n_q    <= 6'd1;
			end
			OP_SMUL: sp_q <= sprod[51:16];
			OP_SACC: begin
				term_q <= div_q[31:0];
				f_q    <= f_q + div_q[30:0];
				n_q    <= n_q + 6'd1;
			end
			OP_SQ:    aa2_q <= aa2[SQ_IW-1:0];
			OP_RTAKE: r_q <= sq_root;
			OP_FR:    fr_q <= fr[DIV_NW-1:0];
			OP_TTAKE: t_q <= (div_q > DIV_NW'(T_CAP)) ? 27'(T_CAP) : div_q[26:0];
			OP_T2:    t2_q <= tt[52:16];
			OP_AF:    af_q <= af[63:16];
			OP_G1:    gl_q <= 20'(GRAV_Q16) * t2_q[17:0];
			OP_G2:    gh_q <= 20'(GRAV_Q16) * t2_q[36:18];
			OP_Z:     gs_q <= gsum[56:17];
			OP_MISS:  miss_q <= miss_next;
			OP_UPD:   a_q <= a_next;
			OP_CINIT: begin
				x_q   <= 34'(d_q);
				y_q   <= 34'(a_q);
				ang_q <= '0;
				i_q   <= '0;
			end
			OP_CNORM: begin
				if (!stat.norm_done) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			OP_CROT: begin
				if (y_q > 0) begin
					x_q   <= x_q + y_sh;
					y_q   <= y_q - x_sh;
					ang_q <= ang_q + tab;
				end else begin
					x_q   <= x_q - y_sh;
					y_q   <= y_q + x_sh;
					ang_q <= ang_q - tab;
				end
				i_q <= i_q + 5'd1;
			end
			OP_FIN: begin
				if (ang_q > $signed(19'(HALF_PI_Q16)))
					pitch_q <= 18'(HALF_PI_Q16);
				else if (ang_q < -$signed(19'(HALF_PI_Q16)))
					pitch_q <= -18'(HALF_PI_Q16);
				else
					pitch_q <= ang_q[17:0];
				flight_q <= (ft_sum > 28'(TIME_MAX)) ? 20'(TIME_MAX) : ft_sum[19:0];
			end
			default: ;
		endcase
	end

	// Status back to the controller
	always_comb begin
		stat.div_done   = div_done;
		stat.sqrt_done  = sq_done;
		stat.term_zero  = (div_q == '0);
		stat.n_last     = (n_q == 6'(SER_LAST));
		stat.miss_small = (miss_q < $signed(50'(TOL_Q16))) &&
			(miss_q > -$signed(50'(TOL_Q16)));
		stat.y_zero     = (a_q == '0);
		stat.norm_done  = (x_abs >= 34'(NORM_LIMIT)) || (y_abs >= 34'(NORM_LIMIT));
		stat.rot_last   = (i_q == 5'(CORDIC_STEPS - 1));
	end

	assign pitch_angle = pitch_q;
	assign flight_time = flight_q;

endmodule

// ===== rtl/bps_ctrl.sv =====
// ----------------------------------------------------------------------------
// bps_ctrl
// Solver sequencer: series, correction passes, CORDIC and result strobe.
// ----------------------------------------------------------------------------
module bps_ctrl import bps_pkg::*; #(
	parameter int unsigned MAX_PASSES = DEF_MAX_PASSES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  bps_stat_t stat,
	output bps_cmd_t  cmd,
	output logic      busy,
	output logic      done,
	output logic      converged,
	output logic [4:0] passes_used
);

	localparam int unsigned PW = $clog2(MAX_PASSES + 1);

	bps_state_t    state_q;
	bps_state_t    state_d;
	logic [PW-1:0] passes_q;
	logic          conv_q;
	logic          done_q;
	logic [6:0]    passes_ext;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_U;
			ST_U:     state_d = ST_SMUL;
			ST_SMUL:  state_d = ST_SDIV;
			ST_SDIV:  state_d = ST_SWAIT;
			ST_SWAIT: if (stat.div_done) state_d = ST_SACC;
			ST_SACC: begin
				if (stat.term_zero || stat.n_last)
					state_d = ST_SQ;
				else
					state_d = ST_SMUL;
			end
			ST_SQ:    state_d = ST_RT;
			ST_RT:    state_d = ST_RWAIT;
			ST_RWAIT: if (stat.sqrt_done) state_d = ST_RTAKE;
			ST_RTAKE: state_d = ST_FR;
			ST_FR:    state_d = ST_TDIV;
			ST_TDIV:  state_d = ST_TWAIT;
			ST_TWAIT: if (stat.div_done) state_d = ST_TTAKE;
			ST_TTAKE: state_d = ST_T2;
			ST_T2:    state_d = ST_AF;
			ST_AF:    state_d = ST_G1;
			ST_G1:    state_d = ST_G2;
			ST_G2:    state_d = ST_Z;
			ST_Z:     state_d = ST_MISS;
			ST_MISS:  state_d = ST_UPD;
			ST_UPD: begin
				if (stat.miss_small || passes_q == PW'(MAX_PASSES))
					state_d = ST_CINIT;
				else
					state_d = ST_SQ;
			end
			ST_CINIT: state_d = stat.y_zero ? ST_FIN : ST_CNORM;
			ST_CNORM: if (stat.norm_done) state_d = ST_CROT;
			ST_CROT:  if (stat.rot_last) state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.op         = OP_NONE;
		cmd.div_start  = 1'b0;
		cmd.sqrt_start = 1'b0;
		case (state_q)
			ST_IDLE:  if (start) cmd.op = OP_LOAD;
			ST_U:     cmd.op = OP_U;
			ST_SMUL:  cmd.op = OP_SMUL;
			ST_SDIV: begin
				cmd.op        = OP_SDIV;
				cmd.div_start = 1'b1;
			end
			ST_SACC:  cmd.op = OP_SACC;
			ST_SQ:    cmd.op = OP_SQ;
			ST_RT: begin
				cmd.op         = OP_RT;
				cmd.sqrt_start = 1'b1;
			end
			ST_RTAKE: cmd.op = OP_RTAKE;
			ST_FR:    cmd.op = OP_FR;
			ST_TDIV: begin
				cmd.op        = OP_TDIV;
				cmd.div_start = 1'b1;
			end
			ST_TTAKE: cmd.op = OP_TTAKE;
			ST_T2:    cmd.op = OP_T2;
			ST_AF:    cmd.op = OP_AF;
			ST_G1:    cmd.op = OP_G1;
			ST_G2:    cmd.op = OP_G2;
			ST_Z:     cmd.op = OP_Z;
			ST_MISS:  cmd.op = OP_MISS;
			ST_UPD:   cmd.op = OP_UPD;
			ST_CINIT: cmd.op = OP_CINIT;
			ST_CNORM: cmd.op = OP_CNORM;
			ST_CROT:  cmd.op = OP_CROT;
			ST_FIN:   cmd.op = OP_FIN;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// State, pass count, convergence and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			passes_q <= '0;
			conv_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
			if (state_q == ST_IDLE && start) begin
				passes_q <= '0;
				conv_q   <= 1'b0;
			end
			if (state_q == ST_SQ)
				passes_q <= passes_q + 1'b1;
			if (state_q == ST_UPD && stat.miss_small)
				conv_q <= 1'b1;
		end
	end

	assign passes_ext  = 7'(passes_q);
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign converged   = conv_q;
	assign passes_used = passes_ext[4:0];

endmodule

// ===== rtl/ballistic_pitch_solver.sv =====
// Operation: a setup state after the accepting edge, then the drag series (one divide a term)
// for up to 63 terms, a root and a divide per pass for up to MAX_PASSES passes, then CORDIC:
// init, scaling, 17 rotations and a final state.
// Throughput: one item at a time; busy drops in the done cycle; results cannot be held off.
// Reset: arst_n clears the sequencer and loads the drag and lag defaults.
// ----------------------------------------------------------------------------
// ballistic_pitch_solver
// Iterative pitch and flight-time solver for a drag-modelled trajectory.
// ----------------------------------------------------------------------------
module ballistic_pitch_solver import bps_pkg::*; #(
	parameter int unsigned MAX_PASSES = DEF_MAX_PASSES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [21:0]        distance,
	input  logic signed [21:0] height,
	input  logic [13:0]        launch_speed,
	output logic               done,
	output logic signed [17:0] pitch_angle,
	output logic [19:0]        flight_time,
	output logic               converged,
	output logic [4:0]         passes_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	logic [15:0] drag_q;
	logic [16:0] lag_q;
	bps_cmd_t    cmd;
	bps_stat_t   stat;

	// Configuration registers, written one beat at a time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q <= DRAG_RST;
			lag_q  <= LAG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DRAG: drag_q <= cfg_data[15:0];
				REG_LAG:  lag_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	bps_ctrl #(
		.MAX_PASSES (MAX_PASSES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.converged   (converged),
		.passes_used (passes_used)
	);

	bps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.drag         (drag_q),
		.lag          (lag_q),
		.distance     (distance),
		.height       (height),
		.launch_speed (launch_speed),
		.pitch_angle  (pitch_angle),
		.flight_time  (flight_time)
	);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done strobe longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= 18'sd102944 && pitch_angle >= -18'sd102944))
		else $error("pitch out of range");
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (flight_time <= 20'd655360)) else $error("flight time not saturated");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drag-modelled pitch solver: a queue-fed command
// driver, a config writer and a result monitor, checked against a bit-exact
// fixed-point solver model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import bps_pkg::*;

	localparam int          LIMIT_CYCLES = 12_000_000;
	localparam int          DRAIN_CYCLES = 20;
	localparam logic [1:0]  REG_SPARE_A  = REG_LAG + 2'd1;
	localparam logic [1:0]  REG_SPARE_B  = REG_LAG + 2'd2;

	typedef struct {
		logic [21:0]        rng;
		logic signed [21:0] hgt;
		logic [13:0]        spd;
	} target_t;

	typedef struct {
		logic [17:0] pitch;
		logic [19:0] ftime;
		logic        conv;
		logic [4:0]  passes;
	} aim_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [21:0]        distance;
	logic signed [21:0] height;
	logic [13:0]        launch_speed;
	logic               done;
	logic signed [17:0] pitch_angle;
	logic [19:0]        flight_time;
	logic               converged;
	logic [4:0]         passes_used;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [16:0]        cfg_data;

	target_t     targets_q[$];
	aim_t        aims_q[$];
	longint      drag_k;
	longint      lag_q;
	int          idle_pct;
	int          errors;
	int          cycles;

	ballistic_pitch_solver u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.distance(distance), .height(height), .launch_speed(launch_speed),
		.done(done), .pitch_angle(pitch_angle), .flight_time(flight_time),
		.converged(converged), .passes_used(passes_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Solve one target with the current drag and lag settings
	function automatic aim_t solve_aim(input target_t tg);
		longint d, h, u, f, term, a, zr, miss, ang, x, y, nx, ny;
		longint unsigned v16, aa, rad, root, bitv, t, t2, ft;
		int passes;
		bit conv;
		aim_t res;
		d = tg.rng;
		h = tg.hgt;
		v16 = longint'(tg.spd) << 8;
		u = (drag_k * d) >>> 16;
		if (u > U_CAP) u = U_CAP;
		// drag factor (e^u - 1)/u as a series
		term = 65536;
		f = 65536;
		for (int n = 1; n <= SER_LAST; n++) begin
			term = ((term * u) >>> 16) / (n + 1);
			if (term == 0) break;
			f += term;
		end
		a = h;
		t = 0;
		passes = 0;
		conv = 0;
		while (passes < DEF_MAX_PASSES) begin
			aa = (a < 0) ? -a : a;
			rad = longint'(d) * longint'(d) + aa * aa;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > rad) bitv >>= 2;
			while (bitv != 0) begin
				if (rad >= root + bitv) begin
					rad -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			passes++;
			if (v16 == 0) begin
				t = T_CAP;
			end else begin
				t = (longint'(f) * root) / v16;
				if (t > T_CAP) t = T_CAP;
			end
			t2 = (t * t) >> 16;
			zr = ((a * f) >>> 16) - longint'((longint'(GRAV_Q16) * t2) >> 17);
			miss = h - zr;
			a += miss;
			if (a > longint'(AIM_CAP)) a = AIM_CAP;
			if (a < -longint'(AIM_CAP)) a = -longint'(AIM_CAP);
			if (miss < longint'(TOL_Q16) && miss > -longint'(TOL_Q16)) begin
				conv = 1;
				break;
			end
		end
		// vectoring CORDIC on (d, a)
		ang = 0;
		if (a != 0) begin
			x = d;
			y = a;
			while ((x < 0 ? -x : x) < NORM_LIMIT && (y < 0 ? -y : y) < NORM_LIMIT) begin
				x *= 2;
				y *= 2;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					ang += atan_tab(i);
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					ang -= atan_tab(i);
				end
				x = nx;
				y = ny;
			end
			if (ang > longint'(HALF_PI_Q16)) ang = HALF_PI_Q16;
			if (ang < -longint'(HALF_PI_Q16)) ang = -longint'(HALF_PI_Q16);
		end
		ft = t + lag_q;
		if (ft > TIME_MAX) ft = TIME_MAX;
		res.pitch  = ang[17:0];
		res.ftime  = ft[19:0];
		res.conv   = conv;
		res.passes = passes[4:0];
		return res;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Command driver: retire the accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		target_t cur;
		if (!arst_n) begin
			start        <= 1'b0;
			distance     <= '0;
			height       <= '0;
			launch_speed <= '0;
		end else begin
			if (start && !busy) begin
				cur.rng = distance;
				cur.hgt = height;
				cur.spd = launch_speed;
				aims_q.push_back(solve_aim(cur));
				void'(targets_q.pop_front());
			end
			if (targets_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start        <= 1'b1;
				distance     <= targets_q[0].rng;
				height       <= targets_q[0].hgt;
				launch_speed <= targets_q[0].spd;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Mirror accepted register writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DRAG) drag_k = cfg_data[15:0];
			else if (cfg_index == REG_LAG) lag_q = cfg_data;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		aim_t exp_r;
		if (arst_n && done) begin
			if (aims_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				exp_r = aims_q.pop_front();
				if (pitch_angle !== exp_r.pitch) begin
					$error("pitch_angle exp %0d got %0d", $signed(exp_r.pitch), pitch_angle);
					errors++;
				end
				if (flight_time !== exp_r.ftime) begin
					$error("flight_time exp %0d got %0d", exp_r.ftime, flight_time);
					errors++;
				end
				if (converged !== exp_r.conv) begin
					$error("converged exp %0d got %0d", exp_r.conv, converged);
					errors++;
				end
				if (passes_used !== exp_r.passes) begin
					$error("passes_used exp %0d got %0d", exp_r.passes, passes_used);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[ballistic_pitch_solver] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_target(input logic [21:0] d, input logic [21:0] h,
			input logic [13:0] s);
		target_t tg;
		tg.rng = d;
		tg.hgt = h;
		tg.spd = s;
		targets_q.push_back(tg);
	endtask

	// Hold until every queued target has been answered, then settle
	task automatic drain();
		do @(posedge clk); while (targets_q.size() > 0 || aims_q.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_targets(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				push_target(22'($urandom), 22'($urandom), 14'($urandom));
			else if ($urandom_range(3) == 0)
				push_target(22'($urandom_range(2097152, 1)),
					22'($signed($urandom_range(2097152)) - 1048576),
					14'($urandom_range(10240, 1)));
			else
				// mostly short ranges and realistic speeds
				push_target(22'($urandom_range(655360, 1)),
					22'($signed($urandom_range(262144)) - 131072),
					14'($urandom_range(10240, 2560)));
		end
	endtask

	initial begin
		errors    = 0;
		cycles    = 0;
		idle_pct  = 7;
		drag_k    = DRAG_RST;
		lag_q     = LAG_RST;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DRAG;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and special cases at reset settings
		push_target(22'd1, 22'd0, 14'd10240);
		push_target(22'd2097152, 22'd1048576, 14'd10240);
		push_target(22'd2097152, -22'sd1048576, 14'd1);
		push_target(22'h3FFFFF, 22'h1FFFFF, 14'h3FFF);
		push_target(22'h3FFFFF, 22'h200000, 14'h3FFF);
		push_target(22'd0, 22'd65536, 14'd5000);
		push_target(22'd0, -22'sd65536, 14'd5000);
		push_target(22'd0, 22'd0, 14'd5000);
		push_target(22'd327680, 22'd0, 14'd0);
		push_target(22'd327680, 22'd32768, 14'd0);
		push_target(22'd655360, 22'd65536, 14'd7680);
		push_target(22'd1966080, 22'd524288, 14'd256);
		push_target(22'd65536, 22'd0, 14'd3840);
		push_target(22'd1, 22'd1, 14'd1);
		drain();

		// Idle-free stretch, then wait until everything is answered
		idle_pct = 0;
		random_targets(40);
		drain();
		idle_pct = 7;

		// Zero drag and zero lag
		write_reg(REG_DRAG, 17'd0);
		write_reg(REG_LAG, 17'd0);
		push_target(22'd2097152, 22'd1048576, 14'd10240);
		push_target(22'd131072, -22'sd65536, 14'd512);
		random_targets(50);
		drain();

		// Strongest drag and the top lag of the random settings
		write_reg(REG_DRAG, 17'hFFFF);
		write_reg(REG_LAG, 17'd65536);
		push_target(22'h3FFFFF, 22'h1FFFFF, 14'h3FFF);
		random_targets(50);
		drain();

		// Smallest nonzero drag, all lag bits, writes to unused indexes
		write_reg(REG_DRAG, 17'h10001);
		write_reg(REG_LAG, 17'h1FFFF);
		write_reg(REG_SPARE_A, 17'h1FFFF);
		write_reg(REG_SPARE_B, 17'd0);
		random_targets(50);
		drain();

		// Random settings
		for (int p = 0; p < 2; p++) begin
			write_reg(REG_DRAG, 17'($urandom_range(65535, 1)));
			write_reg(REG_LAG, 17'($urandom_range(65536)));
			random_targets(50);
			drain();
		end

		if (errors == 0)
			$display("[ballistic_pitch_solver] OK");
		else
			$display("[ballistic_pitch_solver] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bps_pkg.sv
rtl/bps_div.sv
rtl/bps_sqrt.sv
rtl/bps_dp.sv
rtl/bps_ctrl.sv
rtl/ballistic_pitch_solver.sv
tb/tb_top.sv
